// File: rtl/dffd_pkg.sv
// Shared types and constants for the dual-format frame deframer.
package dffd_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] REG_ACCEPT_MODE  = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_MAGIC_FIRST  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_MAGIC_SECOND = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_MAX_PAYLOAD  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_LEGACY_MIN   = 3'd4;

    localparam logic [1:0] MODE_BOTH   = 2'd0;
    localparam logic [1:0] MODE_MARKED = 2'd1;
    localparam logic [1:0] MODE_LEGACY = 2'd2;

    localparam logic FMT_MARKED = 1'b0;
    localparam logic FMT_LEGACY = 1'b1;

    localparam logic [1:0]  RST_ACCEPT_MODE  = MODE_BOTH;
    localparam logic [7:0]  RST_MAGIC_FIRST  = 8'hAA;
    localparam logic [7:0]  RST_MAGIC_SECOND = 8'h55;
    localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd1024;
    localparam logic [15:0] RST_LEGACY_MIN   = 16'd1;

    typedef struct packed {
        logic [1:0]  accept_mode;
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
        logic [15:0] max_payload;
        logic [15:0] legacy_min_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        frame_last;
        logic        frame_format;
        logic [15:0] frame_length;
        logic [15:0] oversized_total;
        logic [31:0] resync_total;
    } result_t;

endpackage

// File: rtl/dffd_cfg.sv
// Configuration register file of the deframer.
module dffd_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dffd_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [dffd_pkg::CfgDataWidth-1:0]   cfg_data,
    output dffd_pkg::cfg_t                      cfg
);

    dffd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accept_mode        <= dffd_pkg::RST_ACCEPT_MODE;
            cfg_reg.magic_first        <= dffd_pkg::RST_MAGIC_FIRST;
            cfg_reg.magic_second       <= dffd_pkg::RST_MAGIC_SECOND;
            cfg_reg.max_payload        <= dffd_pkg::RST_MAX_PAYLOAD;
            cfg_reg.legacy_min_payload <= dffd_pkg::RST_LEGACY_MIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dffd_pkg::REG_ACCEPT_MODE:  cfg_reg.accept_mode  <= cfg_data[1:0];
                dffd_pkg::REG_MAGIC_FIRST:  cfg_reg.magic_first  <= cfg_data[7:0];
                dffd_pkg::REG_MAGIC_SECOND: cfg_reg.magic_second <= cfg_data[7:0];
                dffd_pkg::REG_MAX_PAYLOAD:  cfg_reg.max_payload  <= cfg_data;
                dffd_pkg::REG_LEGACY_MIN:   cfg_reg.legacy_min_payload <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/dffd_hunt.sv
// Header hunt, payload tracking and error counters of the deframer.
module dffd_hunt (
    input  logic                aclk,
    input  logic                aresetn,
    input  dffd_pkg::cfg_t      cfg,
    input  logic                beat_accept,
    input  logic [7:0]          in_byte,
    input  logic                drop_partial,
    output logic                res_valid,
    output dffd_pkg::result_t   res
);

    logic [3:0][7:0] window_reg, window_next;
    logic [1:0]      fill_reg, fill_next;
    logic            in_payload_reg, in_payload_next;
    logic [15:0]     bytes_left_reg, bytes_left_next;
    logic [15:0]     length_reg, length_next;
    logic            format_reg, format_next;
    logic [15:0]     oversized_reg, oversized_next;
    logic [31:0]     resync_reg, resync_next;

    logic [3:0][7:0] win;
    logic [15:0]     marked_len;
    logic [15:0]     legacy_len;
    logic            magic_hit;
    logic            legacy_ok;
    logic            slide;
    logic            take;
    logic [15:0]     left_dec;

    always_comb begin
        win             = window_reg;
        win[fill_reg]   = in_byte;
        marked_len      = {win[3], win[2]};
        legacy_len      = {win[1], win[0]};
        magic_hit       = (cfg.accept_mode != dffd_pkg::MODE_LEGACY) &&
                          (win[0] == cfg.magic_first) && (win[1] == cfg.magic_second);
        legacy_ok       = (win[2] == 8'd0) && (win[3] == 8'd0) &&
                          (legacy_len >= cfg.legacy_min_payload) &&
                          (legacy_len <= cfg.max_payload);
        left_dec        = bytes_left_reg - 16'd1;

        window_next     = window_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        bytes_left_next = bytes_left_reg;
        length_next     = length_reg;
        format_next     = format_reg;
        oversized_next  = oversized_reg;
        resync_next     = resync_reg;
        slide           = 1'b0;
        take            = 1'b0;
        res_valid       = 1'b0;
        res.payload_byte = 8'd0;
        res.has_byte     = 1'b0;
        res.frame_last   = 1'b1;

        if (drop_partial) begin
            window_next     = '0;
            fill_next       = 2'd0;
            in_payload_next = 1'b0;
            bytes_left_next = 16'd0;
        end else if (in_payload_reg) begin
            bytes_left_next  = left_dec;
            in_payload_next  = (left_dec != 16'd0);
            res_valid        = 1'b1;
            res.payload_byte = in_byte;
            res.has_byte     = 1'b1;
            res.frame_last   = (left_dec == 16'd0);
        end else if (fill_reg != 2'd3) begin
            window_next = win;
            fill_next   = fill_reg + 2'd1;
        end else begin
            if (magic_hit) begin
                if (marked_len > cfg.max_payload) begin
                    slide = 1'b1;
                    if (oversized_reg != 16'hFFFF) begin
                        oversized_next = oversized_reg + 16'd1;
                    end
                end else begin
                    take        = 1'b1;
                    format_next = dffd_pkg::FMT_MARKED;
                    length_next = marked_len;
                end
            end else if (cfg.accept_mode == dffd_pkg::MODE_MARKED || !legacy_ok) begin
                slide = 1'b1;
            end else begin
                take        = 1'b1;
                format_next = dffd_pkg::FMT_LEGACY;
                length_next = legacy_len;
            end

            if (slide) begin
                window_next = {8'd0, win[3], win[2], win[1]};
                fill_next   = 2'd3;
                if (resync_reg != 32'hFFFF_FFFF) begin
                    resync_next = resync_reg + 32'd1;
                end
            end
            if (take) begin
                window_next = '0;
                fill_next   = 2'd0;
                if (length_next == 16'd0) begin
                    res_valid = 1'b1;
                end else begin
                    in_payload_next = 1'b1;
                    bytes_left_next = length_next;
                end
            end
        end

        res.frame_format    = format_next;
        res.frame_length    = length_next;
        res.oversized_total = oversized_next;
        res.resync_total    = resync_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= '0;
            fill_reg       <= 2'd0;
            in_payload_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
            length_reg     <= 16'd0;
            format_reg     <= dffd_pkg::FMT_MARKED;
            oversized_reg  <= 16'd0;
            resync_reg     <= 32'd0;
        end else if (beat_accept) begin
            window_reg     <= window_next;
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            bytes_left_reg <= bytes_left_next;
            length_reg     <= length_next;
            format_reg     <= format_next;
            oversized_reg  <= oversized_next;
            resync_reg     <= resync_next;
        end
    end

    a_payload_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> bytes_left_reg != 16'd0)
        else $error("Payload in progress with no bytes left.");

    a_window_empty_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> fill_reg == 2'd0 && window_reg == '0)
        else $error("Header window not empty during payload.");

    a_resync_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> resync_reg >= $past(resync_reg))
        else $error("Resync counter decreased.");

endmodule

// File: rtl/dffd_obuf.sv
// Output register stage of the deframer.
module dffd_obuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                beat_accept,
    input  logic                res_valid,
    input  dffd_pkg::result_t   res,
    output logic                load_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dffd_pkg::result_t   m_res
);

    logic              valid_reg, valid_next;
    dffd_pkg::result_t res_reg;

    assign load_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_res      = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (beat_accept && res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept && res_valid) begin
            res_reg <= res;
        end
    end

    a_empty_frame_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !res_reg.has_byte |->
            res_reg.frame_last && res_reg.frame_length == 16'd0 &&
            res_reg.payload_byte == 8'd0)
        else $error("Empty frame marker with wrong contents.");

endmodule

// File: rtl/dual_format_frame_deframer.sv
// Top level of the dual-format frame deframer.
// The block takes one received byte per input beat on the s_ channel and
// hunts for a four-byte header: either two sync bytes and a little-endian
// length, or a little-endian length followed by two zero bytes.
// Once a header is accepted, each following byte leaves on the m_ channel
// as a payload beat, with m_tlast on the final byte of the frame.
// A header announcing zero length gives one beat with no payload byte.
// Setting s_tuser on an input beat discards the window and any partial frame.
// Each result beat also carries the header format, the announced length
// and the saturating oversized and resync counters.
// Registers are written through the cfg_ channel; the user must write them only while the stream is idle, not enforced.
// An accepted input beat's result beat is registered and appears in the next cycle.
// The block takes one byte per cycle while s_tready is high; the decode is a single registered pass.
// A stalled receiver holds the result register and s_tready drops only
// while that register is full and m_tready is low.
// Reset clears the window, the frame state and the counters and sets the registers to their defaults.
module dual_format_frame_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dffd_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [dffd_pkg::CfgDataWidth-1:0]   cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // in_byte
    input  logic                                s_tuser,  // drop_partial
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // payload_byte, frame_length, oversized_total, resync_total
    output logic [71:0]                         m_tdata,
    output logic [1:0]                          m_tuser,  // has_byte, frame_format
    output logic                                m_tlast
);

    dffd_pkg::cfg_t    cfg;
    dffd_pkg::result_t res;
    dffd_pkg::result_t m_res;
    logic              res_valid;
    logic              beat_accept;
    logic              load_ready;

    assign s_tready    = load_ready;
    assign beat_accept = s_tvalid && load_ready;

    dffd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dffd_hunt u_hunt (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .beat_accept  (beat_accept),
        .in_byte      (s_tdata),
        .drop_partial (s_tuser),
        .res_valid    (res_valid),
        .res          (res)
    );

    dffd_obuf u_obuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .res_valid   (res_valid),
        .res         (res),
        .load_ready  (load_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (m_res)
    );

    assign m_tdata = {m_res.resync_total, m_res.oversized_total,
                      m_res.frame_length, m_res.payload_byte};
    assign m_tuser = {m_res.frame_format, m_res.has_byte};
    assign m_tlast = m_res.frame_last;

endmodule
